/* hw/rtl/exact_substring_search_macros.svh */
// Assertion helpers shared by the search block.
`ifndef EXACT_SUBSTRING_SEARCH_MACROS_SVH
`define EXACT_SUBSTRING_SEARCH_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ESS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ESS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/ess_pkg.sv */
package ess_pkg;

  localparam int PATTERN_MAX_DEF = 64;
  localparam int OFFSET_BITS_DEF = 16;
  localparam int QUEUE_DEPTH     = 2;

  typedef enum logic {
    OP_PATTERN = 1'b0,
    OP_TEXT    = 1'b1
  } op_t;

  typedef struct packed {
    op_t        operation;
    logic [7:0] data_byte;
    logic       last;
  } item_t;

endpackage

/* hw/rtl/ess_fifo.sv */
module ess_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = ess_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  import ess_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] rd_ptr, wr_ptr;
  logic [CNT_W-1:0] count;
  logic             push_ok, pop_ok;

  assign full    = count == CNT_W'(DEPTH);
  assign empty   = count == '0;
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push_ok && !pop_ok) begin
        count <= count + CNT_W'(1);
      end else if (pop_ok && !push_ok) begin
        count <= count - CNT_W'(1);
      end
    end
  end

`include "exact_substring_search_macros.svh"

  `ESS_ASSERT_NOW(a_count_range, clk, rst, 1'b1, count <= CNT_W'(DEPTH), "fifo count out of range")
  `ESS_ASSERT_NOW(a_empty_ptrs, clk, rst, empty, rd_ptr == wr_ptr, "empty fifo with unequal pointers")
  `ESS_ASSERT_NEXT(a_push_grows, clk, rst, push_ok && !pop_ok, count == $past(count) + CNT_W'(1), "push did not grow fifo")
  `ESS_ASSERT_NEXT(a_pop_shrinks, clk, rst, pop_ok && !push_ok, count == $past(count) - CNT_W'(1), "pop did not shrink fifo")

endmodule

/* hw/rtl/ess_engine.sv */
module ess_engine #(
  parameter int PATTERN_MAX = ess_pkg::PATTERN_MAX_DEF,
  parameter int OFFSET_BITS = ess_pkg::OFFSET_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  ess_pkg::item_t       item,
  output logic                 item_take,
  input  logic                 res_full,
  output logic                 res_push,
  output logic                 found,
  output logic [OFFSET_BITS-1:0] match_start,
  output logic [OFFSET_BITS-1:0] match_last,
  output logic [OFFSET_BITS:0]   remaining_length
);
  import ess_pkg::*;

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int POS_W = OFFSET_BITS + 1;

  // pat[0] holds the newest (final) pattern byte, win[0] the newest text byte
  logic [7:0]             pat [PATTERN_MAX];
  logic [7:0]             win [PATTERN_MAX];
  logic [LEN_W-1:0]       len, len_next, len_base;
  logic                   closed, closed_next;
  logic [POS_W-1:0]       pos, pos_next, pos_inc;
  logic                   seen, seen_next;
  logic [OFFSET_BITS-1:0] end_ofs, end_next, end_fin;
  logic [PATTERN_MAX-1:0] hit;
  logic                   is_text, room, hit_now, match_fin;

  always_comb begin
    is_text   = item.operation == OP_TEXT;
    item_take = item_valid && !(is_text && item.last && res_full);
    len_base  = closed ? '0 : len;
    room      = len_base < LEN_W'(PATTERN_MAX);
    pos_inc   = pos[OFFSET_BITS] ? pos : pos + POS_W'(1);

    // positions beyond the pattern length always pass
    hit[0] = (len == '0) || (item.data_byte == pat[0]);
    for (int k = 1; k < PATTERN_MAX; k++) begin
      hit[k] = (LEN_W'(k) >= len) || (win[k-1] == pat[k]);
    end
    hit_now = !seen && (len != '0) && !pos[OFFSET_BITS]
              && ((POS_W+1)'(len) <= (POS_W+1)'(pos) + (POS_W+1)'(1)) && (&hit);

    match_fin = seen || hit_now;
    end_fin   = hit_now ? pos[OFFSET_BITS-1:0] : end_ofs;
  end

  always_comb begin
    len_next    = len;
    closed_next = closed;
    pos_next    = pos;
    seen_next   = seen;
    end_next    = end_ofs;
    res_push    = 1'b0;
    if (item_take) begin
      if (!is_text) begin
        len_next    = len_base + LEN_W'(room);
        closed_next = item.last;
        pos_next    = '0;
        seen_next   = 1'b0;
        end_next    = '0;
      end else begin
        closed_next = 1'b1;
        pos_next    = pos_inc;
        if (hit_now) begin
          seen_next = 1'b1;
          end_next  = pos[OFFSET_BITS-1:0];
        end
        if (item.last) begin
          res_push  = 1'b1;
          pos_next  = '0;
          seen_next = 1'b0;
          end_next  = '0;
        end
      end
    end
  end

  always_comb begin
    if (len == '0) begin
      found            = 1'b1;
      match_start      = '0;
      match_last       = '0;
      remaining_length = pos_inc;
    end else if (match_fin) begin
      found            = 1'b1;
      match_start      = end_fin + OFFSET_BITS'(1) - OFFSET_BITS'(len);
      match_last       = end_fin;
      remaining_length = pos_inc - {1'b0, end_fin};
    end else begin
      found            = 1'b0;
      match_start      = '0;
      match_last       = '0;
      remaining_length = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len     <= '0;
      closed  <= 1'b1;
      pos     <= '0;
      seen    <= 1'b0;
      end_ofs <= '0;
    end else begin
      len     <= len_next;
      closed  <= closed_next;
      pos     <= pos_next;
      seen    <= seen_next;
      end_ofs <= end_next;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && !is_text && room) begin
      pat[0] <= item.data_byte;
      for (int i = 1; i < PATTERN_MAX; i++) begin
        pat[i] <= pat[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && is_text) begin
      win[0] <= item.data_byte;
      for (int i = 1; i < PATTERN_MAX; i++) begin
        win[i] <= win[i-1];
      end
    end
  end

`include "exact_substring_search_macros.svh"

  `ESS_ASSERT_NOW(a_len_range, clk, rst, 1'b1, len <= LEN_W'(PATTERN_MAX), "pattern length overflow")
  `ESS_ASSERT_NOW(a_push_cause, clk, rst, res_push, item_take && is_text && item.last && !res_full, "result without final text item")
  `ESS_ASSERT_NEXT(a_load_clears, clk, rst, item_take && !is_text, (pos == '0) && !seen, "pattern load left text state")
  `ESS_ASSERT_NOW(a_seen_in_range, clk, rst, seen, !closed || (len != '0), "match latched with empty pattern")

endmodule

/* hw/rtl/exact_substring_search.sv */
// Exact substring search. Push pattern bytes (operation 0, last on the final
// one), then text bytes (operation 1, last on the final one); one result per
// text gives the first match. The block takes one item per clock cycle while
// the engine is not stalled: a small input queue feeds a search engine that
// compares each text byte and the preceding PATTERN_MAX-1 bytes against the
// whole pattern combinationally in parallel, and results go through a small
// output queue. A final text byte's result reaches the result ports through
// the input and output queue registers. The engine stalls only when the
// output queue is full and the next queued item is a final text byte; full
// rises once the two-entry input queue backs up behind it.
module exact_substring_search #(
  parameter int PATTERN_MAX = ess_pkg::PATTERN_MAX_DEF,
  parameter int OFFSET_BITS = ess_pkg::OFFSET_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic                   operation,
  input  logic [7:0]             data_byte,
  input  logic                   last,
  input  logic                   pop,
  output logic                   empty,
  output logic                   found,
  output logic [OFFSET_BITS-1:0] match_start,
  output logic [OFFSET_BITS-1:0] match_last,
  output logic [OFFSET_BITS:0]   remaining_length
);
  import ess_pkg::*;

  localparam int RES_W = 3 * OFFSET_BITS + 2;

  item_t                  in_item, q_item;
  logic [$bits(item_t)-1:0] q_data;
  logic                   q_empty, q_take;
  logic                   res_push, res_full;
  logic                   e_found;
  logic [OFFSET_BITS-1:0] e_start, e_last;
  logic [OFFSET_BITS:0]   e_rem;
  logic [RES_W-1:0]       res_in, res_out;

  assign in_item = '{operation: op_t'(operation), data_byte: data_byte, last: last};
  assign q_item  = item_t'(q_data);

  ess_fifo #(
    .WIDTH($bits(item_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_in_q (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(in_item),
    .full (full),
    .pop  (q_take),
    .rdata(q_data),
    .empty(q_empty)
  );

  ess_engine #(
    .PATTERN_MAX(PATTERN_MAX),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_engine (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (!q_empty),
    .item            (q_item),
    .item_take       (q_take),
    .res_full        (res_full),
    .res_push        (res_push),
    .found           (e_found),
    .match_start     (e_start),
    .match_last      (e_last),
    .remaining_length(e_rem)
  );

  assign res_in = {e_found, e_start, e_last, e_rem};

  ess_fifo #(
    .WIDTH(RES_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_out_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .wdata(res_in),
    .full (res_full),
    .pop  (pop),
    .rdata(res_out),
    .empty(empty)
  );

  assign {found, match_start, match_last, remaining_length} = res_out;

endmodule

/* bench/tb_exact_substring_search.sv */
`timescale 1ns / 100ps

module tb_exact_substring_search;
  import ess_pkg::*;

  localparam int PMAX = PATTERN_MAX_DEF;
  localparam int OB = OFFSET_BITS_DEF;
  localparam int unsigned OFF_LIMIT = 1 << OB;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_ITEMS = 1200;

  typedef struct packed {
    logic          found;
    logic [OB-1:0] match_start;
    logic [OB-1:0] match_last;
    logic [OB:0]   remaining_length;
  } report_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] b;
    logic       fin;
    logic       typed;
    report_t    want;
  } step_row_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          push = 1'b0;
  logic          full;
  logic          operation = OP_PATTERN;
  logic [7:0]    data_byte = 8'h00;
  logic          last = 1'b0;
  logic          pop = 1'b0;
  logic          empty;
  logic          found;
  logic [OB-1:0] match_start;
  logic [OB-1:0] match_last;
  logic [OB:0]   remaining_length;

  exact_substring_search u_top (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .operation(operation),
    .data_byte(data_byte),
    .last(last),
    .pop(pop),
    .empty(empty),
    .found(found),
    .match_start(match_start),
    .match_last(match_last),
    .remaining_length(remaining_length)
  );

  always #4 clk = ~clk;

  // search state mirror
  logic [7:0]  pat_mem [PMAX];
  int unsigned pat_len = 0;
  bit          pat_closed = 1'b1;
  logic [7:0]  recent [PMAX];
  int unsigned txt_pos = 0;
  bit          hit_seen = 1'b0;
  int unsigned hit_end = 0;

  report_t     pending_reports [$];
  logic [7:0]  cur_pat [$];
  int          burst_left = 0;
  int          items_accepted = 0;
  int          reports_checked = 0;
  int          errors = 0;
  int          cycle_count = 0;
  int          stall_left = 0;

  step_row_t directed_rows [21] = '{
    // empty pattern right after reset
    '{OP_TEXT,    8'h00, 1'b0, 1'b0, '0},
    '{OP_TEXT,    8'hFF, 1'b1, 1'b1, '{1'b1, 16'd0, 16'd0, 17'd2}},
    '{OP_PATTERN, 8'h41, 1'b0, 1'b0, '0},
    '{OP_PATTERN, 8'h42, 1'b1, 1'b0, '0},
    '{OP_TEXT,    8'h00, 1'b0, 1'b0, '0},
    '{OP_TEXT,    8'h41, 1'b0, 1'b0, '0},
    '{OP_TEXT,    8'h42, 1'b1, 1'b1, '{1'b1, 16'd1, 16'd2, 17'd1}},
    // no match
    '{OP_TEXT,    8'h42, 1'b0, 1'b0, '0},
    '{OP_TEXT,    8'h41, 1'b1, 1'b1, '{1'b0, 16'd0, 16'd0, 17'd0}},
    // pattern byte abandons a text; unflagged pattern closed by text
    '{OP_TEXT,    8'h41, 1'b0, 1'b0, '0},
    '{OP_PATTERN, 8'hFF, 1'b0, 1'b0, '0},
    '{OP_PATTERN, 8'h00, 1'b0, 1'b0, '0},
    '{OP_TEXT,    8'hFF, 1'b0, 1'b0, '0},
    '{OP_TEXT,    8'h00, 1'b1, 1'b1, '{1'b1, 16'd0, 16'd1, 17'd1}},
    '{OP_PATTERN, 8'h00, 1'b1, 1'b0, '0},
    '{OP_TEXT,    8'h01, 1'b0, 1'b0, '0},
    '{OP_TEXT,    8'h00, 1'b1, 1'b1, '{1'b1, 16'd1, 16'd1, 17'd1}},
    '{OP_PATTERN, 8'hFF, 1'b1, 1'b0, '0},
    '{OP_TEXT,    8'hFF, 1'b1, 1'b1, '{1'b1, 16'd0, 16'd0, 17'd1}},
    // second occurrence must not replace the first
    '{OP_TEXT,    8'hFF, 1'b0, 1'b0, '0},
    '{OP_TEXT,    8'hFF, 1'b1, 1'b1, '{1'b1, 16'd0, 16'd0, 17'd2}}
  };

  task automatic scan_byte(input op_t op, input logic [7:0] b, input logic fin,
                           output bit emit, output report_t r);
    bit same;
    int k;
    emit = 1'b0;
    r = '0;
    if (op == OP_PATTERN) begin
      if (pat_closed) begin
        pat_len = 0;
        pat_closed = 1'b0;
      end
      if (pat_len < PMAX) begin
        pat_mem[pat_len] = b;
        pat_len++;
      end
      if (fin) pat_closed = 1'b1;
      txt_pos = 0;
      hit_seen = 1'b0;
      hit_end = 0;
    end else begin
      pat_closed = 1'b1;
      if (!hit_seen && pat_len > 0 && txt_pos < OFF_LIMIT && txt_pos + 1 >= pat_len) begin
        same = (b == pat_mem[pat_len-1]);
        for (k = 1; k < pat_len; k++)
          if (recent[k-1] != pat_mem[pat_len-1-k]) same = 1'b0;
        if (same) begin
          hit_seen = 1'b1;
          hit_end = txt_pos;
        end
      end
      for (k = PMAX - 1; k > 0; k--) recent[k] = recent[k-1];
      recent[0] = b;
      if (txt_pos < OFF_LIMIT) txt_pos++;
      if (fin) begin
        emit = 1'b1;
        if (pat_len == 0) begin
          r.found = 1'b1;
          r.remaining_length = txt_pos[OB:0];
        end else if (hit_seen) begin
          r.found = 1'b1;
          r.match_start = OB'(hit_end + 1 - pat_len);
          r.match_last = hit_end[OB-1:0];
          r.remaining_length = (OB+1)'(txt_pos - hit_end);
        end
        txt_pos = 0;
        hit_seen = 1'b0;
        hit_end = 0;
      end
    end
  endtask

  task automatic send_item(input op_t op, input logic [7:0] b, input logic fin,
                           output bit emit);
    report_t r;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(0, 15) == 0) gap = $urandom_range(7, 20);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    push <= 1'b1;
    operation <= op;
    data_byte <= b;
    last <= fin;
    do @(posedge clk); while (full);
    scan_byte(op, b, fin, emit, r);
    if (emit) pending_reports.push_back(r);
    items_accepted++;
  endtask

  task automatic send_bytes(input op_t op, input logic [7:0] q [$], input bit flag_end);
    bit emit;
    int i;
    for (i = 0; i < q.size(); i++)
      send_item(op, q[i], flag_end && (i == q.size() - 1), emit);
  endtask

  // random text, biased toward the current pattern's bytes, sometimes with it planted
  task automatic gen_text(input int len, output logic [7:0] txt [$]);
    int at;
    int i;
    txt = {};
    repeat (len) begin
      if (cur_pat.size() > 0 && $urandom_range(0, 9) < 6)
        txt.push_back(cur_pat[$urandom_range(0, cur_pat.size() - 1)]);
      else if ($urandom_range(0, 3) == 0)
        txt.push_back(8'($urandom));
      else
        txt.push_back(8'h41 + 8'($urandom_range(0, 3)));
    end
    if (cur_pat.size() > 0 && cur_pat.size() <= PMAX && cur_pat.size() <= len &&
        $urandom_range(0, 1) == 1) begin
      at = $urandom_range(0, len - cur_pat.size());
      for (i = 0; i < cur_pat.size(); i++) txt[at+i] = cur_pat[i];
    end
  endtask

  // result side: check, then choose the next pop
  always @(posedge clk) begin
    report_t want;
    int mode;
    cycle_count++;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_reports.size() == 0) begin
          $error("unexpected result: found=%0d start=%0d last=%0d remaining=%0d",
                 found, match_start, match_last, remaining_length);
          errors++;
        end else begin
          want = pending_reports.pop_front();
          reports_checked++;
          if (found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, found);
            errors++;
          end
          if (match_start !== want.match_start) begin
            $error("match_start: expected %0d, got %0d", want.match_start, match_start);
            errors++;
          end
          if (match_last !== want.match_last) begin
            $error("match_last: expected %0d, got %0d", want.match_last, match_last);
            errors++;
          end
          if (remaining_length !== want.remaining_length) begin
            $error("remaining_length: expected %0d, got %0d",
                   want.remaining_length, remaining_length);
            errors++;
          end
        end
      end
      mode = (cycle_count / 300) % 3;
      if (mode == 0) begin
        pop <= 1'b1;
      end else if (mode == 1) begin
        pop <= ($urandom_range(0, 9) < 7);
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 20);
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_reports.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin : stimulus
    logic [7:0] txt [$];
    bit emit;
    int kind;
    int n;
    int row;
    int random_goal;
    for (n = 0; n < PMAX; n++) recent[n] = 8'h00;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (row = 0; row < $size(directed_rows); row++) begin
      send_item(directed_rows[row].op, directed_rows[row].b, directed_rows[row].fin, emit);
      if (emit && directed_rows[row].typed)
        pending_reports[pending_reports.size() - 1] = directed_rows[row].want;
    end

    random_goal = items_accepted + RANDOM_ITEMS;
    while (items_accepted < random_goal) begin
      kind = $urandom_range(0, 99);
      if (kind < 95) begin
        n = $urandom_range(0, 99);
        n = (n < 80) ? $urandom_range(1, 6) :
            (n < 97) ? $urandom_range(7, PMAX) : $urandom_range(PMAX + 1, PMAX + 6);
        cur_pat = {};
        repeat (n)
          cur_pat.push_back(($urandom_range(0, 1) == 0) ? 8'h41 + 8'($urandom_range(0, 3))
                                                        : 8'($urandom));
        // 70..84: pattern left open, closed by the text that follows
        send_bytes(OP_PATTERN, cur_pat, kind < 70 || kind >= 85);
        if (kind >= 85) begin
          // partial text, abandoned by whatever pattern load comes next
          gen_text($urandom_range(1, 10), txt);
          send_bytes(OP_TEXT, txt, 1'b0);
        end else begin
          repeat ($urandom_range(1, 4)) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 100) : $urandom_range(1, 30);
            gen_text(n, txt);
            send_bytes(OP_TEXT, txt, 1'b1);
          end
        end
      end else begin
        send_item(op_t'($urandom_range(0, 1)), 8'($urandom), 1'($urandom_range(0, 1)), emit);
      end
    end
    push <= 1'b0;

    while (pending_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d items sent, %0d results checked", items_accepted, reports_checked);
    $display("covered empty/overflow/open patterns, abandoned texts, random idling on both sides");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
